// ===== design/lsfa_pkg.sv =====
// Shared types and constants of the LED slider fade animator.
`timescale 1ns / 1ps

package lsfa_pkg;

    // Fixed field widths of the channels
    localparam int OPCODE_W    = 2;
    localparam int NOW_W       = 32;
    localparam int LEVEL_W     = 4;
    localparam int LED_IDX_W   = 4;
    localparam int CHAN_W      = 8;
    localparam int SETTLE_W    = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // Channel order inside one colour
    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    // Fixed update mask, one bit per LED, LEDs past bit 8 read zero
    localparam int          MASK_SEL_W = 5;
    localparam logic [31:0] DRIVE_MASK = 32'h0000_01FC;

    // Register reset values
    localparam logic [CHAN_W-1:0]   RST_TARGET    = 8'd255;
    localparam logic [CHAN_W-1:0]   RST_FADE_STEP = 8'd6;
    localparam logic [CHAN_W-1:0]   RST_THRESHOLD = 8'd6;
    localparam logic [SETTLE_W-1:0] RST_SETTLE    = 16'd700;

    typedef logic [CHAN_W-1:0] t_chan;
    typedef t_chan [2:0]       t_rgb;

    typedef enum logic [OPCODE_W-1:0] {
        OP_FRAME     = 2'd0,
        OP_SET_LEVEL = 2'd1,
        OP_UNMUTE    = 2'd2
    } t_opcode;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_RED       = 3'd0,
        CFG_GREEN     = 3'd1,
        CFG_BLUE      = 3'd2,
        CFG_FADE_STEP = 3'd3,
        CFG_THRESHOLD = 3'd4,
        CFG_SETTLE    = 3'd5,
        CFG_SLIDER    = 3'd6
    } t_cfg_idx;

    // Commands from the controller to the datapath
    typedef enum logic [3:0] {
        DP_NOP,
        DP_FRAME_LOAD,
        DP_SET_LEVEL,
        DP_UNMUTE_LOAD,
        DP_P1_STEP,
        DP_READY_UPD,
        DP_P2_STEP,
        DP_POST,
        DP_UNMUTE_STEP,
        DP_EMIT
    } t_dp_op;

    // Status from the datapath to the controller
    typedef struct packed {
        logic p1_run;    // fade walk runs this frame
        logic rec_go;    // refill cascade runs this frame
        logic p2_more;   // current LED sits above the cursor
        logic out_free;  // output register can take a word
    } t_dp_status;

endpackage

// ===== design/lsfa_if.sv =====
// Channel interfaces: input items, result words and register writes.
`timescale 1ns / 1ps

interface lsfa_in_if import lsfa_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [OPCODE_W-1:0] opcode;
    logic [NOW_W-1:0]    now_ms;
    logic [LEVEL_W-1:0]  level;
    logic                muted;

    modport source(output valid, opcode, now_ms, level, muted, input ready);
    modport sink(input valid, opcode, now_ms, level, muted, output ready);
endinterface

interface lsfa_out_if import lsfa_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [LED_IDX_W-1:0] led_index;
    logic [CHAN_W-1:0]    red;
    logic [CHAN_W-1:0]    green;
    logic [CHAN_W-1:0]    blue;
    logic                 drive_enable;
    logic                 anim_ready;
    logic                 recover_pending;
    logic                 fast_frame;
    logic                 last;

    modport source(output valid, led_index, red, green, blue, drive_enable, anim_ready,
                   recover_pending, fast_frame, last, input ready);
    modport sink(input valid, led_index, red, green, blue, drive_enable, anim_ready,
                 recover_pending, fast_frame, last, output ready);
endinterface

interface lsfa_cfg_if import lsfa_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

// ===== design/lsfa_datapath.sv =====
// Datapath: registers, LED colour store and per-LED fade and refill logic.
`timescale 1ns / 1ps

module lsfa_datapath import lsfa_pkg::*; #(
    parameter int NUM_LEDS  = 10,
    parameter int TIME_BITS = 32,
    localparam int IDX_W    = $clog2(NUM_LEDS)
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_dp_op                 i_cmd,
    input  logic [IDX_W-1:0]       i_idx,
    output t_dp_status             o_status,
    input  logic                   i_cfg_we,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic [NOW_W-1:0]       i_now_ms,
    input  logic [LEVEL_W-1:0]     i_level,
    input  logic                   i_muted,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output logic [LED_IDX_W-1:0]   o_led_index,
    output logic [CHAN_W-1:0]      o_red,
    output logic [CHAN_W-1:0]      o_green,
    output logic [CHAN_W-1:0]      o_blue,
    output logic                   o_drive_enable,
    output logic                   o_anim_ready,
    output logic                   o_recover_pending,
    output logic                   o_fast_frame,
    output logic                   o_last
);

    localparam int               CUR_W    = IDX_W + 1;
    localparam int               LVL_W    = (LEVEL_W > IDX_W) ? LEVEL_W : IDX_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);
    localparam logic [LVL_W-1:0] LAST_LVL = LVL_W'(NUM_LEDS - 1);

    // Configuration registers
    t_rgb                r_tgt;
    t_chan               r_fade_step;
    t_chan               r_threshold;
    logic [SETTLE_W-1:0] r_settle;
    logic                r_slider_en;

    // Animation state
    t_rgb                    r_colour [NUM_LEDS];
    logic [NUM_LEDS-1:0]     r_touched;
    logic signed [CUR_W-1:0] r_cursor;
    logic [IDX_W-1:0]        r_goal;
    logic [TIME_BITS-1:0]    r_change_time;
    logic [TIME_BITS-1:0]    r_ready_time;
    logic                    r_ready;
    logic                    r_recover;
    logic                    r_fast;

    // Per-frame scratch
    logic [TIME_BITS-1:0] r_now;
    logic                 r_muted;
    logic                 r_since_gt;
    logic                 r_rt_gt;
    logic                 r_all_ready;
    logic                 r_recovering;
    logic                 r_rec_run;
    logic                 r_lit_prev;

    // Output register
    logic                 r_out_valid;
    logic [LED_IDX_W-1:0] r_led_index;
    t_rgb                 r_out_rgb;
    logic                 r_drive_enable;
    logic                 r_out_ready_flag;
    logic                 r_out_recover;
    logic                 r_out_fast;
    logic                 r_out_last;

    t_rgb                    w_cur;
    logic [2:0][CHAN_W:0]    w_sum;
    logic [2:0]              w_rise_ok;
    logic [2:0]              w_fall_ok;
    t_rgb                    w_rose;
    t_rgb                    w_fell;
    logic                    w_can_rise;
    logic                    w_any_fall;
    logic                    w_is_last;
    logic                    w_is_cursor;
    logic signed [CUR_W-1:0] w_idx_s;
    logic signed [CUR_W-1:0] w_goal_s;
    t_rgb                    n_p1_colour;
    logic                    n_p1_touched;
    logic                    n_p1_busy;
    logic                    w_p1_move;
    logic signed [CUR_W-1:0] n_cursor;
    logic                    w_go;
    t_rgb                    n_p2_colour;
    logic                    w_p2_rising;
    t_rgb                    n_unm_colour;
    t_rgb                    n_colour;
    logic                    w_colour_we;
    logic                    w_rec_go;
    logic                    n_recover;
    logic [TIME_BITS-1:0]    w_now_t;
    logic [TIME_BITS-1:0]    w_settle_t;
    logic [TIME_BITS-1:0]    w_since;
    logic [TIME_BITS-1:0]    w_ready_dt;
    logic                    w_lvl_ok;
    logic [IDX_W-1:0]        w_pos;

    // An LED counts as lit when any channel reaches the threshold
    function automatic logic f_lit(input t_rgb colour, input t_chan thr);
        logic hit;
        hit = 1'b0;
        for (int c = 0; c < 3; c++) begin
            if (colour[c] >= thr) hit = 1'b1;
        end
        return hit;
    endfunction

    // Read the LED under the walk and form its rise and fall candidates
    assign w_cur = r_colour[i_idx];

    always_comb begin
        for (int c = 0; c < 3; c++) begin
            w_sum[c]     = {1'b0, w_cur[c]} + {1'b0, r_fade_step};
            w_rise_ok[c] = w_sum[c] <= {1'b0, r_tgt[c]};
            w_rose[c]    = w_rise_ok[c] ? w_sum[c][CHAN_W-1:0] : w_cur[c];
            w_fall_ok[c] = w_cur[c] >= r_fade_step;
            w_fell[c]    = w_fall_ok[c] ? (w_cur[c] - r_fade_step) : w_cur[c];
        end
    end

    assign w_can_rise  = |w_rise_ok;
    assign w_any_fall  = |w_fall_ok;
    assign w_is_last   = (i_idx == LAST_IDX);
    assign w_idx_s     = $signed({1'b0, i_idx});
    assign w_goal_s    = $signed({1'b0, r_goal});
    assign w_is_cursor = (r_cursor == w_idx_s);

    // Fade walk: touched LEDs rise, the others fall, the cursor LED rises
    always_comb begin
        n_p1_colour  = w_cur;
        n_p1_touched = r_touched[i_idx];
        n_p1_busy    = 1'b0;
        if (!w_is_cursor) begin
            if (r_touched[i_idx]) begin
                if (w_can_rise) begin
                    n_p1_colour = w_rose;
                    n_p1_busy   = 1'b1;
                end else begin
                    n_p1_touched = 1'b0;
                    n_p1_colour  = r_tgt;
                end
            end else if (w_any_fall) begin
                n_p1_colour = w_fell;
                n_p1_busy   = 1'b1;
            end else begin
                n_p1_colour = '0;
            end
        end else begin
            if (w_can_rise) begin
                n_p1_colour = w_rose;
                n_p1_busy   = 1'b1;
            end else begin
                n_p1_colour = r_tgt;
            end
            n_p1_touched = 1'b1;
        end
    end

    // Step the cursor toward the goal once its LED is lit
    assign w_p1_move = w_is_cursor && f_lit(n_p1_colour, r_threshold)
                       && ((w_goal_s != r_cursor) || !r_slider_en);
    assign n_cursor  = (w_goal_s > r_cursor) ? (r_cursor + 1'b1) : (r_cursor - 1'b1);

    // Refill cascade: an LED refills when the one above it is lit
    assign w_go        = w_is_last || r_lit_prev;
    assign w_p2_rising = w_go && w_can_rise;
    assign n_p2_colour = w_go ? (w_can_rise ? w_rose : r_tgt) : w_cur;

    // Unmute: full colour at and above the goal, dark below
    assign n_unm_colour = (i_idx >= r_goal) ? r_tgt : '0;

    // Select the colour write for this cycle
    always_comb begin
        w_colour_we = 1'b0;
        n_colour    = w_cur;
        case (i_cmd)
            DP_P1_STEP: begin
                w_colour_we = 1'b1;
                n_colour    = n_p1_colour;
            end
            DP_P2_STEP: begin
                w_colour_we = 1'b1;
                n_colour    = n_p2_colour;
            end
            DP_UNMUTE_STEP: begin
                w_colour_we = 1'b1;
                n_colour    = n_unm_colour;
            end
            default: begin
                w_colour_we = 1'b0;
            end
        endcase
    end

    // Time differences wrap modulo the time width
    assign w_now_t    = TIME_BITS'(i_now_ms);
    assign w_settle_t = TIME_BITS'(r_settle);
    assign w_since    = w_now_t - r_change_time;
    assign w_ready_dt = w_now_t - r_ready_time;

    // Goal position for a level request
    assign w_lvl_ok = LVL_W'(i_level) <= LAST_LVL;
    assign w_pos    = IDX_W'(LAST_LVL - LVL_W'(i_level));

    // A readiness set this frame restarts its timer, so it blocks the refill
    assign w_rec_go  = r_all_ready && r_ready && r_rt_gt && r_since_gt && r_recover;
    assign n_recover = (r_rec_run && !r_recovering) ? 1'b0 : r_recover;

    assign o_status.p1_run   = !r_since_gt || !r_ready;
    assign o_status.rec_go   = w_rec_go;
    assign o_status.p2_more  = w_idx_s > r_cursor;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    // Hold the configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tgt       <= {RST_TARGET, RST_TARGET, RST_TARGET};
            r_fade_step <= RST_FADE_STEP;
            r_threshold <= RST_THRESHOLD;
            r_settle    <= RST_SETTLE;
            r_slider_en <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RED:       r_tgt[CH_RED]   <= i_cfg_data[CHAN_W-1:0];
                CFG_GREEN:     r_tgt[CH_GREEN] <= i_cfg_data[CHAN_W-1:0];
                CFG_BLUE:      r_tgt[CH_BLUE]  <= i_cfg_data[CHAN_W-1:0];
                CFG_FADE_STEP: r_fade_step     <= i_cfg_data[CHAN_W-1:0];
                CFG_THRESHOLD: r_threshold     <= i_cfg_data[CHAN_W-1:0];
                CFG_SETTLE:    r_settle        <= i_cfg_data[SETTLE_W-1:0];
                CFG_SLIDER:    r_slider_en     <= i_cfg_data[0];
                default:       r_slider_en     <= r_slider_en;
            endcase
        end
    end

    // Write back one LED colour per cycle while a step command is issued
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NUM_LEDS; k++) begin
                r_colour[k] <= '0;
            end
        end else if (w_colour_we) begin
            r_colour[i_idx] <= n_colour;
        end
    end

    // Advance the animation state on each command
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_touched     <= '0;
            r_cursor      <= $signed(CUR_W'(NUM_LEDS - 1));
            r_goal        <= LAST_IDX;
            r_change_time <= '0;
            r_ready_time  <= '0;
            r_ready       <= 1'b1;
            r_recover     <= 1'b0;
            r_fast        <= 1'b0;
            r_now         <= '0;
            r_muted       <= 1'b0;
            r_since_gt    <= 1'b0;
            r_rt_gt       <= 1'b0;
            r_all_ready   <= 1'b1;
            r_recovering  <= 1'b0;
            r_rec_run     <= 1'b0;
            r_lit_prev    <= 1'b0;
        end else begin
            case (i_cmd)
                DP_FRAME_LOAD: begin
                    r_now        <= w_now_t;
                    r_muted      <= i_muted;
                    r_since_gt   <= w_since > w_settle_t;
                    r_rt_gt      <= w_ready_dt > w_settle_t;
                    r_all_ready  <= 1'b1;
                    r_recovering <= 1'b0;
                    r_rec_run    <= 1'b0;
                end
                DP_SET_LEVEL: begin
                    if (w_lvl_ok && (r_goal != w_pos)) begin
                        if ((!r_fast || r_ready) && r_slider_en) r_touched <= '0;
                        r_change_time <= w_now_t;
                        r_goal        <= w_pos;
                        r_recover     <= 1'b1;
                        r_ready       <= 1'b0;
                    end
                end
                DP_UNMUTE_LOAD: begin
                    r_ready   <= 1'b1;
                    r_recover <= 1'b1;
                end
                DP_P1_STEP: begin
                    r_touched[i_idx] <= n_p1_touched;
                    if (n_p1_busy && !w_is_last) r_all_ready <= 1'b0;
                    if (w_p1_move) r_cursor <= n_cursor;
                end
                DP_READY_UPD: begin
                    if (!r_ready && r_all_ready) r_ready_time <= r_now;
                    r_ready   <= !r_muted && r_all_ready && (w_goal_s == r_cursor);
                    r_rec_run <= w_rec_go;
                end
                DP_P2_STEP: begin
                    if (w_p2_rising) r_recovering <= 1'b1;
                    r_lit_prev <= f_lit(n_p2_colour, r_threshold);
                end
                DP_POST: begin
                    r_recover <= n_recover;
                    r_fast    <= !r_muted && (!r_ready || n_recover);
                end
                default: begin
                    r_lit_prev <= r_lit_prev;
                end
            endcase
        end
    end

    // Output word valid: set on load, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd == DP_EMIT) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Load the output word for the LED under the walk
    always_ff @(posedge i_clk) begin
        if (i_cmd == DP_EMIT) begin
            r_led_index      <= LED_IDX_W'(i_idx);
            r_out_rgb        <= w_cur;
            r_drive_enable   <= DRIVE_MASK[MASK_SEL_W'(i_idx)];
            r_out_ready_flag <= r_ready;
            r_out_recover    <= r_recover;
            r_out_fast       <= r_fast;
            r_out_last       <= w_is_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_led_index       = r_led_index;
    assign o_red             = r_out_rgb[CH_RED];
    assign o_green           = r_out_rgb[CH_GREEN];
    assign o_blue            = r_out_rgb[CH_BLUE];
    assign o_drive_enable    = r_drive_enable;
    assign o_anim_ready      = r_out_ready_flag;
    assign o_recover_pending = r_out_recover;
    assign o_fast_frame      = r_out_fast;
    assign o_last            = r_out_last;

endmodule

// ===== design/lsfa_ctrl.sv =====
// Controller: sequences the fade walk, refill cascade, unmute fill and word output.
`timescale 1ns / 1ps

module lsfa_ctrl import lsfa_pkg::*; #(
    parameter int NUM_LEDS = 10,
    localparam int IDX_W   = $clog2(NUM_LEDS)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic [OPCODE_W-1:0] i_opcode,
    output logic                o_in_ready,
    input  t_dp_status          i_status,
    output t_dp_op              o_cmd,
    output logic [IDX_W-1:0]    o_idx
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_LEDS - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_P1,
        S_FIN,
        S_P2,
        S_POST,
        S_UNM,
        S_EMIT
    } t_state;

    t_state           r_state;
    logic [IDX_W-1:0] r_idx;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_idx      = r_idx;

    // Issue the datapath command for the current state
    always_comb begin
        o_cmd = DP_NOP;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    case (i_opcode)
                        OP_FRAME:     o_cmd = DP_FRAME_LOAD;
                        OP_SET_LEVEL: o_cmd = DP_SET_LEVEL;
                        OP_UNMUTE:    o_cmd = DP_UNMUTE_LOAD;
                        default:      o_cmd = DP_NOP;
                    endcase
                end
            end
            S_P1:    o_cmd = i_status.p1_run ? DP_P1_STEP : DP_NOP;
            S_FIN:   o_cmd = DP_READY_UPD;
            S_P2:    o_cmd = i_status.p2_more ? DP_P2_STEP : DP_NOP;
            S_POST:  o_cmd = DP_POST;
            S_UNM:   o_cmd = DP_UNMUTE_STEP;
            S_EMIT:  o_cmd = i_status.out_free ? DP_EMIT : DP_NOP;
            default: o_cmd = DP_NOP;
        endcase
    end

    // Advance state and the LED counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    if (i_in_valid) begin
                        case (i_opcode)
                            OP_FRAME:  r_state <= S_P1;
                            OP_UNMUTE: r_state <= S_UNM;
                            default:   r_state <= S_IDLE;
                        endcase
                    end
                end
                S_P1: begin
                    if (!i_status.p1_run || (r_idx == LAST_IDX)) begin
                        r_state <= S_FIN;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_FIN: begin
                    if (i_status.rec_go) begin
                        r_state <= S_P2;
                        r_idx   <= LAST_IDX;
                    end else begin
                        r_state <= S_POST;
                    end
                end
                S_P2: begin
                    // walk down until the LED just above the cursor
                    if (!i_status.p2_more || (r_idx == '0)) begin
                        r_state <= S_POST;
                    end else begin
                        r_idx <= r_idx - 1'b1;
                    end
                end
                S_POST: begin
                    r_state <= S_EMIT;
                    r_idx   <= '0;
                end
                S_UNM: begin
                    if (r_idx == LAST_IDX) begin
                        r_state <= S_EMIT;
                        r_idx   <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_EMIT: begin
                    if (i_status.out_free) begin
                        if (r_idx == LAST_IDX) begin
                            r_state <= S_IDLE;
                            r_idx   <= '0;
                        end else begin
                            r_idx <= r_idx + 1'b1;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== design/led_slider_fade_animator_top.sv =====
// Top level of the LED slider fade animator: controller plus datapath.
//
//  channel  dir  payload                                        word moves when
//  i_in     in   opcode, now_ms, level, muted                   valid && ready
//  o_out    out  led_index, red, green, blue, drive_enable,     valid && ready
//                anim_ready, recover_pending, fast_frame, last
//  i_cfg    in   index, data                                    valid && ready (ready tied high)
//
// Set level is taken straight from idle. Unmute fills one LED per cycle, then sends one
// output word per cycle while the output is free. A frame runs the fade walk over every
// LED when it is active, the ready update, the refill cascade over the LEDs above the
// cursor when it runs, a post step and the output walk. The walk and the cascade never
// run in the same frame. The single colour read port is walked one LED a cycle.
// Reset is synchronous and active low and restores every register but the output word fields, and every LED colour.
// A stalled output holds the word and pauses the output walk only; input is taken
// again as soon as the last word of a run is in the output register.
`timescale 1ns / 1ps

module led_slider_fade_animator_top import lsfa_pkg::*; #(
    parameter int NUM_LEDS  = 10,
    parameter int TIME_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    lsfa_in_if.sink        i_in,
    lsfa_out_if.source     o_out,
    lsfa_cfg_if.sink       i_cfg
);

    localparam int IDX_W = $clog2(NUM_LEDS);

    t_dp_op           w_cmd;
    t_dp_status       w_status;
    logic [IDX_W-1:0] w_idx;

    // Register writes are always taken
    assign i_cfg.ready = 1'b1;

    lsfa_ctrl #(
        .NUM_LEDS (NUM_LEDS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_opcode   (i_in.opcode),
        .o_in_ready (i_in.ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_idx      (w_idx)
    );

    lsfa_datapath #(
        .NUM_LEDS  (NUM_LEDS),
        .TIME_BITS (TIME_BITS)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (w_cmd),
        .i_idx             (w_idx),
        .o_status          (w_status),
        .i_cfg_we          (i_cfg.valid),
        .i_cfg_index       (i_cfg.index),
        .i_cfg_data        (i_cfg.data),
        .i_now_ms          (i_in.now_ms),
        .i_level           (i_in.level),
        .i_muted           (i_in.muted),
        .o_out_valid       (o_out.valid),
        .i_out_ready       (o_out.ready),
        .o_led_index       (o_out.led_index),
        .o_red             (o_out.red),
        .o_green           (o_out.green),
        .o_blue            (o_out.blue),
        .o_drive_enable    (o_out.drive_enable),
        .o_anim_ready      (o_out.anim_ready),
        .o_recover_pending (o_out.recover_pending),
        .o_fast_frame      (o_out.fast_frame),
        .o_last            (o_out.last)
    );

endmodule

// ===== design/lsfa_checker.sv =====
// Port-level checks on the animator output stream, bound to the top level.
`timescale 1ns / 1ps

module lsfa_checker import lsfa_pkg::*; #(
    parameter int NUM_LEDS = 10
) (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_out_valid,
    input logic                 i_out_ready,
    input logic [LED_IDX_W-1:0] i_led_index,
    input logic [CHAN_W-1:0]    i_red,
    input logic [CHAN_W-1:0]    i_green,
    input logic [CHAN_W-1:0]    i_blue,
    input logic                 i_drive_enable,
    input logic                 i_anim_ready,
    input logic                 i_recover_pending,
    input logic                 i_fast_frame,
    input logic                 i_last
);

    // Hold a stalled word
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
        && $stable({i_led_index, i_red, i_green, i_blue, i_drive_enable, i_anim_ready,
                    i_recover_pending, i_fast_frame, i_last}))
        else $error("output word changed while stalled");

    // Stream LEDs back to back in index order within a run
    a_next_led: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && !i_last |=> i_out_valid
        && (i_led_index == LED_IDX_W'($past(i_led_index) + 1'b1)))
        else $error("run of LED words broken or out of order");

    // Mark only the top LED as the end of a run
    a_last_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_last |-> (i_led_index == LED_IDX_W'(NUM_LEDS - 1)))
        else $error("end of run on the wrong LED");

    // Ask for fast frames only while unsettled or refilling
    a_fast_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_fast_frame |-> !i_anim_ready || i_recover_pending)
        else $error("fast frame requested with the bar settled");

endmodule

bind led_slider_fade_animator_top lsfa_checker #(
    .NUM_LEDS (NUM_LEDS)
) u_lsfa_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_led_index       (o_out.led_index),
    .i_red             (o_out.red),
    .i_green           (o_out.green),
    .i_blue            (o_out.blue),
    .i_drive_enable    (o_out.drive_enable),
    .i_anim_ready      (o_out.anim_ready),
    .i_recover_pending (o_out.recover_pending),
    .i_fast_frame      (o_out.fast_frame),
    .i_last            (o_out.last)
);
